/* sv/sspr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_pkg : shared types and constants of the stepper speed ramp controller
// Field widths, register indexes, reset values, direction codes and the
// command bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package sspr_pkg;

	// field widths
	localparam int POS_W     = 32;
	localparam int ERR_W     = POS_W + 1;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int SPEED_W   = 17;
	localparam int HALF_W    = 14;
	localparam int DIR_W     = 2;
	localparam int PROD_W    = ERR_W + CFG_W;       // signed error times unsigned gain
	localparam int WREF_W    = 32;
	localparam int SLEW_W    = WREF_W + 1;
	localparam int DEN_W     = CFG_W + 1;           // twice a 16-bit magnitude

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DECEL = 2'd3;

	// register reset values (gain 10.0 in Q8.8)
	localparam logic [CFG_W-1:0] GAIN_RST  = 16'd2560;
	localparam logic [CFG_W-1:0] MAX_RST   = 16'd800;
	localparam logic [CFG_W-1:0] ACCEL_RST = 16'd50;
	localparam logic [CFG_W-1:0] DECEL_RST = 16'd50;

	// step timer defaults
	localparam int TIMER_HZ_DEF     = 100000;
	localparam int TIMER_PERIOD_DEF = 10000;

	// direction codes
	localparam logic [DIR_W-1:0] DIR_STOP = 2'b00;
	localparam logic [DIR_W-1:0] DIR_FWD  = 2'b01;
	localparam logic [DIR_W-1:0] DIR_REV  = 2'b11;

	// controller to datapath commands
	typedef struct packed {
		logic load;      // capture the error of an accepted beat
		logic mul;       // register the gain product
		logic sat;       // truncate and saturate the product
		logic slew;      // slew limit against the kept speed
		logic clamp;     // magnitude clamp, commit speed, start divider
		logic div;       // one restoring divider step
		logic out_load;  // load the output register
	} cmd_t;

	// bits of the timer numerator (TIMER_HZ * TIMER_PERIOD)
	function automatic int num_width(input int hz, input int per);
		logic [63:0] n;
		n = 64'(hz) * 64'(per);
		return $clog2(n + 64'd1);
	endfunction

endpackage : sspr_pkg
`default_nettype wire

/* sv/sspr_ifs.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_in_if / sspr_out_if : valid/ready channels of the controller
// Input beat carries the two positions, output beat the speed result.
// ----------------------------------------------------------------------------
interface sspr_in_if;
	import sspr_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] target_position;
	logic signed [POS_W-1:0] actual_position;

	modport source (output valid, output target_position, output actual_position,
		input ready);
	modport sink (input valid, input target_position, input actual_position,
		output ready);
endinterface : sspr_in_if

interface sspr_out_if;
	import sspr_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [SPEED_W-1:0] new_speed;
	logic        [HALF_W-1:0]  half_period_ticks;
	logic signed [DIR_W-1:0]   move_dir;
	logic                      stopped;
	logic                      speed_changed;

	modport source (output valid, output new_speed, output half_period_ticks,
		output move_dir, output stopped, output speed_changed, input ready);
	modport sink (input valid, input new_speed, input half_period_ticks,
		input move_dir, input stopped, input speed_changed, output ready);
endinterface : sspr_out_if
`default_nettype wire

/* sv/sspr_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_ctrl : sequencing state machine of the speed ramp controller
// Steps one beat through multiply, saturate, slew, clamp and the serial
// divider, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sspr_ctrl
	import sspr_pkg::*;
#(
	parameter int DIV_STEPS = num_width(TIMER_HZ_DEF, TIMER_PERIOD_DEF)
) (
	input  wire  clk,
	input  wire  arst_n,
	input  wire  in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire  out_ready,
	output cmd_t cmd
);

	localparam int CNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_MUL   = 3'd1;
	localparam logic [2:0] S_SAT   = 3'd2;
	localparam logic [2:0] S_SLEW  = 3'd3;
	localparam logic [2:0] S_CLAMP = 3'd4;
	localparam logic [2:0] S_DIV   = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]       state_q;
	logic [2:0]       state_d;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             in_fire;
	logic             out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_load  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// command decode
	always_comb begin
		cmd          = '0;
		cmd.load     = in_fire;
		cmd.mul      = (state_q == S_MUL);
		cmd.sat      = (state_q == S_SAT);
		cmd.slew     = (state_q == S_SLEW);
		cmd.clamp    = (state_q == S_CLAMP);
		cmd.div      = (state_q == S_DIV);
		cmd.out_load = out_load;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (in_fire) state_d = S_MUL;
			S_MUL:   state_d = S_SAT;
			S_SAT:   state_d = S_SLEW;
			S_SLEW:  state_d = S_CLAMP;
			S_CLAMP: state_d = S_DIV;
			S_DIV:   if (cnt_q == '0) state_d = S_FIN;
			S_FIN:   if (out_load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// divider step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == S_CLAMP) begin
			cnt_q <= CNT_W'(DIV_STEPS - 1);
		end else if (state_q == S_DIV && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	// output beat pending
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_fin_waits_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && !out_load) |-> (out_valid_q && !out_ready))
		else $error("result held back without a stalled output");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid_q)
		else $error("output register loaded but not flagged valid");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> (state_q == S_MUL))
		else $error("accepted beat did not start the multiply");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && cnt_q == '0) |=> (state_q == S_FIN))
		else $error("divider overran its step count");
`endif

endmodule : sspr_ctrl
`default_nettype wire

/* sv/sspr_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sspr_datapath : arithmetic of the speed ramp controller
// Configuration registers, error and gain product, saturation, slew limit,
// magnitude clamp, kept speed, serial half period divider, output register.
// ----------------------------------------------------------------------------
module sspr_datapath
	import sspr_pkg::*;
#(
	parameter int TIMER_HZ     = TIMER_HZ_DEF,
	parameter int TIMER_PERIOD = TIMER_PERIOD_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire  cmd_t                 cmd,
	input  wire                        cfg_we,
	input  wire  [CFG_IDX_W-1:0]       cfg_idx,
	input  wire  [CFG_W-1:0]           cfg_wdata,
	input  wire  signed [POS_W-1:0]    target_position,
	input  wire  signed [POS_W-1:0]    actual_position,
	output logic signed [SPEED_W-1:0]  new_speed,
	output logic [HALF_W-1:0]          half_period_ticks,
	output logic signed [DIR_W-1:0]    move_dir,
	output logic                       stopped,
	output logic                       speed_changed
);

	localparam logic [63:0] NUM   = 64'(TIMER_HZ) * 64'(TIMER_PERIOD);
	localparam int          NUM_W = num_width(TIMER_HZ, TIMER_PERIOD);
	localparam int          Q_W   = PROD_W - 8;     // product after dropping fraction

	// configuration registers
	logic [CFG_W-1:0] gain_q, max_q, accel_q, decel_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q  <= GAIN_RST;
			max_q   <= MAX_RST;
			accel_q <= ACCEL_RST;
			decel_q <= DECEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_GAIN:  gain_q  <= cfg_wdata;
				REG_MAX:   max_q   <= cfg_wdata;
				REG_ACCEL: accel_q <= cfg_wdata;
				REG_DECEL: decel_q <= cfg_wdata;
				default:   gain_q  <= gain_q;
			endcase
		end
	end

	// error capture and gain product
	logic signed [ERR_W-1:0]  err_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [PROD_W-1:0] prod_full;

	assign prod_full = err_q * $signed({1'b0, gain_q});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			err_q <= ERR_W'(target_position) - ERR_W'(actual_position);
		end
		if (cmd.mul) begin
			prod_q <= prod_full;
		end
	end

	// truncate toward zero, saturate to 32 bits
	logic signed [PROD_W-1:0] prod_adj;
	logic signed [Q_W-1:0]    prod_int;
	logic signed [WREF_W-1:0] wref_q;

	assign prod_adj = prod_q + (prod_q[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
	assign prod_int = Q_W'(prod_adj >>> 8);

	always_ff @(posedge clk) begin
		if (cmd.sat) begin
			if (prod_int > Q_W'(32'sh7FFF_FFFF)) begin
				wref_q <= 32'sh7FFF_FFFF;
			end else if (prod_int < -Q_W'(64'sh8000_0000)) begin
				wref_q <= 32'sh8000_0000;
			end else begin
				wref_q <= prod_int[WREF_W-1:0];
			end
		end
	end

	// slew limit against the kept speed
	logic signed [SPEED_W-1:0] speed_q;
	logic signed [SLEW_W:0]    rise, fall;
	logic signed [SLEW_W-1:0]  wslew_q;

	assign rise = (SLEW_W+1)'(wref_q) - (SLEW_W+1)'(speed_q);
	assign fall = (SLEW_W+1)'(speed_q) - (SLEW_W+1)'(wref_q);

	always_ff @(posedge clk) begin
		if (cmd.slew) begin
			if (rise > $signed({2'b00, accel_q})) begin
				wslew_q <= SLEW_W'(speed_q) + $signed(SLEW_W'(accel_q));
			end else if (fall > $signed({2'b00, decel_q})) begin
				wslew_q <= SLEW_W'(speed_q) - $signed(SLEW_W'(decel_q));
			end else begin
				wslew_q <= SLEW_W'(wref_q);
			end
		end
	end

	// magnitude clamp and kept speed
	logic signed [SLEW_W-1:0]  lim_pos;
	logic signed [SPEED_W-1:0] wnew;
	logic                      changed_q;

	assign lim_pos = $signed(SLEW_W'(max_q));

	always_comb begin
		if (wslew_q > lim_pos) begin
			wnew = SPEED_W'(lim_pos);
		end else if (wslew_q < -lim_pos) begin
			wnew = SPEED_W'(-lim_pos);
		end else begin
			wnew = SPEED_W'(wslew_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q <= '0;
		end else if (cmd.clamp) begin
			speed_q <= wnew;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			changed_q <= (wnew != speed_q);
		end
	end

	// restoring divider: NUM / (2 * |speed|), one quotient bit a cycle
	logic [CFG_W-1:0]   mag;
	logic [DEN_W-1:0]   den;
	logic [DEN_W-1:0]   rem_q;
	logic [NUM_W-1:0]   quo_q;
	logic [DEN_W:0]     trial;
	logic               fits;

	assign mag   = speed_q[SPEED_W-1] ? CFG_W'(-speed_q) : CFG_W'(speed_q);
	assign den   = {mag, 1'b0};
	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (cmd.clamp) begin
			rem_q <= '0;
			quo_q <= NUM[NUM_W-1:0];
		end else if (cmd.div) begin
			rem_q <= fits ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	// output register
	logic [NUM_W-1:0] capped;
	logic             is_zero;

	assign capped  = (quo_q > NUM_W'(TIMER_PERIOD)) ? NUM_W'(TIMER_PERIOD) : quo_q;
	assign is_zero = (speed_q == '0);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			new_speed         <= speed_q;
			stopped           <= is_zero;
			speed_changed     <= changed_q;
			half_period_ticks <= is_zero ? '0 : HALF_W'(capped);
			if (is_zero) begin
				move_dir <= DIR_STOP;
			end else if (speed_q[SPEED_W-1]) begin
				move_dir <= DIR_REV;
			end else begin
				move_dir <= DIR_FWD;
			end
		end
	end

endmodule : sspr_datapath
`default_nettype wire

/* sv/stepper_speed_ramp_controller_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stepper_speed_ramp_controller_core : P position loop with speed ramp
// Error times Q8.8 gain, saturate, slew limit, clamp, half step period.
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    target_position, actual_position
//   out_ch    out  valid/ready    new_speed, half_period_ticks, move_dir,
//                                 stopped, speed_changed
//   cfg       in   cfg_we         cfg_idx, cfg_wdata (no read-back)
//
// One beat at a time: an accepted beat steps through multiply, saturate, slew,
// clamp and the one-bit-a-cycle half period divider, which forms NUM_W quotient
// bits, NUM_W being the bit width of TIMER_HZ * TIMER_PERIOD, before it is registered.
// The next beat is taken as soon as the result sits in the output register,
// even while out_ch is stalled; a stall only holds the final step.
// arst_n clears the sequencer, the kept speed and loads register defaults.
// ----------------------------------------------------------------------------
module stepper_speed_ramp_controller_core
	import sspr_pkg::*;
#(
	parameter int TIMER_HZ     = TIMER_HZ_DEF,
	parameter int TIMER_PERIOD = TIMER_PERIOD_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	sspr_in_if.sink              in_ch,
	sspr_out_if.source           out_ch,
	input  wire                  cfg_we,
	input  wire  [CFG_IDX_W-1:0] cfg_idx,
	input  wire  [CFG_W-1:0]     cfg_wdata
);

	localparam int DIV_STEPS = num_width(TIMER_HZ, TIMER_PERIOD);

	cmd_t cmd;

	// sequencer
	sspr_ctrl #(
		.DIV_STEPS (DIV_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// arithmetic
	sspr_datapath #(
		.TIMER_HZ     (TIMER_HZ),
		.TIMER_PERIOD (TIMER_PERIOD)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg_we            (cfg_we),
		.cfg_idx           (cfg_idx),
		.cfg_wdata         (cfg_wdata),
		.target_position   (in_ch.target_position),
		.actual_position   (in_ch.actual_position),
		.new_speed         (out_ch.new_speed),
		.half_period_ticks (out_ch.half_period_ticks),
		.move_dir          (out_ch.move_dir),
		.stopped           (out_ch.stopped),
		.speed_changed     (out_ch.speed_changed)
	);

endmodule : stepper_speed_ramp_controller_core
`default_nettype wire

/* tb/stepper_speed_ramp_controller_core_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_ramp_controller_core_test : self-checking bench for the core
// Feeds control ticks through the input channel and writes the gain, speed
// limit and slew settings between phases. Each accepted tick is run through a
// local speed-ramp predictor. Every result beat is compared field by field
// with the oldest predicted result. Both channels idle at random. The
// receiver also holds off for long stretches.
// ----------------------------------------------------------------------------
module stepper_speed_ramp_controller_core_test;
	import sspr_pkg::*;

	localparam int LONG_HOLD  = 300;
	localparam int DRAIN_WAIT = 60;
	localparam int MAX_PRINTS = 40;

	typedef enum logic [1:0] {
		STIM_TICK,
		STIM_SET,
		STIM_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t              kind;
		logic signed [POS_W-1:0] target;
		logic signed [POS_W-1:0] actual;
		logic [CFG_IDX_W-1:0]    idx;
		logic [CFG_W-1:0]        data;
	} plan_entry_t;

	typedef struct {
		logic signed [SPEED_W-1:0] new_speed;
		logic [HALF_W-1:0]         half_ticks;
		logic [DIR_W-1:0]          dir;
		logic                      stopped;
		logic                      changed;
	} speed_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]     cfg_wdata;

	sspr_in_if  in_ch ();
	sspr_out_if out_ch ();

	stepper_speed_ramp_controller_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// stimulus plan and predicted results
	plan_entry_t   tick_plan[$];
	speed_result_t speed_forecast[$];

	// predictor copy of the registers and the kept speed
	logic [CFG_W-1:0] gain_r  = GAIN_RST;
	logic [CFG_W-1:0] max_r   = MAX_RST;
	logic [CFG_W-1:0] accel_r = ACCEL_RST;
	logic [CFG_W-1:0] decel_r = DECEL_RST;
	longint           kept_speed = 0;

	logic in_fired;
	logic out_fired;
	logic steady_run = 1'b0;
	int   send_wait = 0;
	int   rdy_wait = 0;
	int   hold_left = 0;
	int   next_hold_at = 200;
	int   results_seen = 0;
	int   fault_count = 0;

	// clock
	initial clk = 1'b0;
	always #2 clk = ~clk;

	task automatic report_fault(input string msg);
		fault_count++;
		if (fault_count <= MAX_PRINTS)
			$display("[%0t] MISMATCH %s", $time, msg);
	endtask

	// gap length: mostly none or short, now and then long
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (steady_run || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic signed [POS_W-1:0] pick_edge();
		case ($urandom_range(0, 4))
			0: return 32'sd0;
			1: return 32'sd1;
			2: return -32'sd1;
			3: return 32'sh7fff_ffff;
			default: return 32'sh8000_0000;
		endcase
	endfunction

	function automatic void add_tick(input logic signed [POS_W-1:0] t,
		input logic signed [POS_W-1:0] a);
		plan_entry_t e;
		e = '{kind: STIM_TICK, target: t, actual: a, idx: REG_GAIN, data: '0};
		tick_plan.push_back(e);
	endfunction

	function automatic void add_setting(input logic [CFG_IDX_W-1:0] i,
		input logic [CFG_W-1:0] v);
		plan_entry_t e;
		e = '{kind: STIM_SET, target: '0, actual: '0, idx: i, data: v};
		tick_plan.push_back(e);
	endfunction

	// mostly tracking runs toward a fixed target, the rest noise and extremes
	task automatic add_random_ticks(input int count);
		int                      n;
		int                      r;
		logic signed [POS_W-1:0] tgt;
		longint                  off;
		n = 0;
		while (n < count) begin
			r = $urandom_range(0, 99);
			if (r < 70) begin
				tgt = $urandom;
				off = longint'($urandom_range(0, 4000)) - 2000;
				if ($urandom_range(0, 3) == 0)
					off = off * 1000;
				repeat ($urandom_range(4, 16)) begin
					add_tick(tgt, tgt - off[POS_W-1:0]);
					off = off - off / 3 + longint'($urandom_range(0, 6)) - 3;
					n++;
				end
			end else if (r < 85) begin
				add_tick($urandom, $urandom);
				n++;
			end else begin
				add_tick(pick_edge(), pick_edge());
				n++;
			end
		end
	endtask

	// speed ramp predictor: gain, saturate, slew limit, clamp, half period
	function automatic speed_result_t ramp_speed(input logic signed [POS_W-1:0] tgt,
		input logic signed [POS_W-1:0] act);
		longint        err;
		longint        prod;
		longint        wref;
		longint        wnew;
		longint        lim;
		longint        mag;
		longint        half;
		speed_result_t r;
		err  = longint'(tgt) - longint'(act);
		prod = err * longint'(gain_r);
		wref = prod / 256;   // signed divide truncates toward zero
		if (wref > 64'sd2147483647)
			wref = 64'sd2147483647;
		if (wref < -64'sd2147483648)
			wref = -64'sd2147483648;
		if (wref - kept_speed > longint'(accel_r))
			wnew = kept_speed + longint'(accel_r);
		else if (kept_speed - wref > longint'(decel_r))
			wnew = kept_speed - longint'(decel_r);
		else
			wnew = wref;
		lim = longint'(max_r);
		if (wnew > lim)
			wnew = lim;
		if (wnew < -lim)
			wnew = -lim;
		r.new_speed = wnew[SPEED_W-1:0];
		if (wnew == 0) begin
			r.half_ticks = '0;
			r.dir        = DIR_STOP;
			r.stopped    = 1'b1;
		end else begin
			mag  = (wnew < 0) ? -wnew : wnew;
			half = (longint'(TIMER_HZ_DEF) * longint'(TIMER_PERIOD_DEF)) / (2 * mag);
			if (half > longint'(TIMER_PERIOD_DEF))
				half = longint'(TIMER_PERIOD_DEF);
			r.half_ticks = half[HALF_W-1:0];
			r.dir        = (wnew < 0) ? DIR_REV : DIR_FWD;
			r.stopped    = 1'b0;
		end
		r.changed  = (wnew != kept_speed);
		kept_speed = wnew;
		return r;
	endfunction

	// input driver: ticks, register writes once idle, and drain pauses
	always @(negedge clk) begin
		plan_entry_t nxt;
		logic        offering;
		logic        we_nxt;
		we_nxt   = 1'b0;
		offering = in_ch.valid && !in_fired;
		if (arst_n && !offering) begin
			if (send_wait > 0) begin
				send_wait--;
				in_ch.valid <= 1'b0;
			end else if (tick_plan.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (tick_plan[0].kind == STIM_TICK) begin
				nxt = tick_plan.pop_front();
				in_ch.valid           <= 1'b1;
				in_ch.target_position <= nxt.target;
				in_ch.actual_position <= nxt.actual;
				send_wait = idle_span();
				if ($urandom_range(0, 79) == 0)
					steady_run = !steady_run;
			end else begin
				// settings and pauses wait for every result to be back
				in_ch.valid <= 1'b0;
				if (speed_forecast.size() == 0) begin
					nxt = tick_plan.pop_front();
					if (nxt.kind == STIM_SET) begin
						we_nxt = 1'b1;
						cfg_idx   <= nxt.idx;
						cfg_wdata <= nxt.data;
					end
				end
			end
		end
		cfg_we <= we_nxt;
	end

	// output ready: random stalls plus long hold-offs while ticks are offered
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else if (results_seen >= next_hold_at && in_ch.valid) begin
			hold_left = LONG_HOLD;
			next_hold_at += 500;
			out_ch.ready <= 1'b0;
		end else if (rdy_wait > 0) begin
			rdy_wait--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
			if (out_fired || $urandom_range(0, 5) == 0)
				rdy_wait = idle_span();
		end
	end

	// monitor: track writes, predict on input beats, check output beats
	always @(posedge clk) begin
		speed_result_t want;
		if (!arst_n) begin
			in_fired  <= 1'b0;
			out_fired <= 1'b0;
		end else begin
			in_fired  <= in_ch.valid && in_ch.ready;
			out_fired <= out_ch.valid && out_ch.ready;
			if (cfg_we) begin
				case (cfg_idx)
					REG_GAIN:  gain_r  = cfg_wdata;
					REG_MAX:   max_r   = cfg_wdata;
					REG_ACCEL: accel_r = cfg_wdata;
					REG_DECEL: decel_r = cfg_wdata;
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				speed_forecast.push_back(ramp_speed(in_ch.target_position,
					in_ch.actual_position));
			if (out_ch.valid && out_ch.ready) begin
				results_seen++;
				if (speed_forecast.size() == 0) begin
					report_fault("result beat with nothing expected");
				end else begin
					want = speed_forecast.pop_front();
					if (out_ch.new_speed !== want.new_speed)
						report_fault($sformatf("new_speed got %0d want %0d",
							out_ch.new_speed, want.new_speed));
					if (out_ch.half_period_ticks !== want.half_ticks)
						report_fault($sformatf("half_period_ticks got %0d want %0d",
							out_ch.half_period_ticks, want.half_ticks));
					if (out_ch.move_dir !== want.dir)
						report_fault($sformatf("move_dir got %b want %b",
							out_ch.move_dir, want.dir));
					if (out_ch.stopped !== want.stopped)
						report_fault($sformatf("stopped got %b want %b",
							out_ch.stopped, want.stopped));
					if (out_ch.speed_changed !== want.changed)
						report_fault($sformatf("speed_changed got %b want %b",
							out_ch.speed_changed, want.changed));
				end
			end
		end
	end

	// plan, reset and end of run
	initial begin
		plan_entry_t drain;
		arst_n                = 1'b0;
		cfg_we                = 1'b0;
		cfg_idx               = REG_GAIN;
		cfg_wdata             = '0;
		in_ch.valid           = 1'b0;
		in_ch.target_position = '0;
		in_ch.actual_position = '0;
		out_ch.ready          = 1'b0;
		drain = '{kind: STIM_DRAIN, target: '0, actual: '0, idx: REG_GAIN, data: '0};

		// reset settings: stop, saturated rise and fall, small reverse speed
		add_tick(32'sd0, 32'sd0);
		add_tick(32'sh7fff_ffff, 32'sh8000_0000);
		add_tick(32'sh8000_0000, 32'sh7fff_ffff);
		add_tick(-32'sd5, 32'sd0);
		add_tick(-32'sd5, 32'sd0);
		// everything at full scale: full slew steps up and down, then clamp to the largest reverse speed
		add_setting(REG_GAIN, 16'hffff);
		add_setting(REG_MAX, 16'hffff);
		add_setting(REG_ACCEL, 16'hffff);
		add_setting(REG_DECEL, 16'hffff);
		add_tick(32'sh7fff_ffff, 32'sh8000_0000);
		add_tick(32'sh8000_0000, 32'sh7fff_ffff);
		add_tick(32'sh8000_0000, 32'sh7fff_ffff);
		// smallest gain: truncation toward zero, slowest speeds hit the cap
		add_setting(REG_GAIN, 16'd1);
		add_tick(-32'sd255, 32'sd0);
		add_tick(-32'sd257, 32'sd0);
		add_tick(32'sd0, -32'sd512);
		// unity gain, then a kept speed above a lowered limit
		add_setting(REG_GAIN, 16'd256);
		add_tick(32'sd50000, 32'sd0);
		add_tick(32'sd65535, 32'sd0);
		add_setting(REG_MAX, 16'd100);
		add_tick(32'sd65535, 32'sd0);
		add_setting(REG_MAX, 16'd0);
		add_tick(32'sd1000, 32'sd0);
		// no slew allowed: the speed cannot leave zero
		add_setting(REG_MAX, MAX_RST);
		add_setting(REG_ACCEL, 16'd0);
		add_setting(REG_DECEL, 16'd0);
		add_tick(32'sd100, 32'sd0);
		add_tick(-32'sd100, 32'sd0);

		// random phases, each with its own settings and a drain halfway
		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: begin
					add_setting(REG_GAIN, 16'hffff);
					add_setting(REG_MAX, 16'hffff);
					add_setting(REG_ACCEL, 16'hffff);
					add_setting(REG_DECEL, 16'hffff);
				end
				1: begin
					add_setting(REG_GAIN, 16'hffff);
					add_setting(REG_MAX, 16'hffff);
					add_setting(REG_ACCEL, 16'd1);
					add_setting(REG_DECEL, 16'd1);
				end
				2: begin
					add_setting(REG_GAIN, 16'd1);
					add_setting(REG_MAX, 16'hffff);
					add_setting(REG_ACCEL, 16'hffff);
					add_setting(REG_DECEL, 16'hffff);
				end
				3: begin
					add_setting(REG_GAIN, GAIN_RST);
					add_setting(REG_MAX, MAX_RST);
					add_setting(REG_ACCEL, ACCEL_RST);
					add_setting(REG_DECEL, DECEL_RST);
				end
				default: begin
					add_setting(REG_GAIN, CFG_W'(($urandom_range(0, 3) == 0) ?
						$urandom_range(0, 65535) : $urandom_range(0, 3000)));
					add_setting(REG_MAX, CFG_W'($urandom_range(0, 65535)));
					add_setting(REG_ACCEL, CFG_W'(($urandom_range(0, 7) == 0) ?
						0 : $urandom_range(0, 3000)));
					add_setting(REG_DECEL, CFG_W'(($urandom_range(0, 7) == 0) ?
						0 : $urandom_range(0, 3000)));
				end
			endcase
			add_random_ticks(56);
			tick_plan.push_back(drain);
			add_random_ticks(56);
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(posedge clk);
		while (tick_plan.size() != 0 || in_ch.valid || speed_forecast.size() != 0);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (fault_count == 0 && speed_forecast.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// watchdog
	initial begin
		#4_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule : stepper_speed_ramp_controller_core_test

/* files.f */
sv/sspr_pkg.sv
sv/sspr_ifs.sv
sv/sspr_ctrl.sv
sv/sspr_datapath.sv
sv/stepper_speed_ramp_controller_core.sv
tb/stepper_speed_ramp_controller_core_test.sv
